// ----- rtl/training_correlator_peak_search_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers; define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef TRAINING_CORRELATOR_PEAK_SEARCH_UNIT_MACROS_SVH
`define TRAINING_CORRELATOR_PEAK_SEARCH_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define TCPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TCPS_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define TCPS_ASSERT(label, prop, msg)
`define TCPS_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

// ----- rtl/tcps_pkg.sv -----
// ----------------------------------------------------------------------------
// tcps_pkg
// Types and constants of the training correlator peak search.
// ----------------------------------------------------------------------------
package tcps_pkg;

  localparam int TRAIN_SYMBOLS_DEF = 12;
  localparam int HOLD_FACTOR_DEF   = 2;
  localparam int MAX_WINDOW_DEF    = 1024;

  localparam int OFFSET_W = 11;
  localparam int POWER_W  = 57;
  localparam int SYM_W    = 4;
  localparam int HOLD_W   = 2;
  localparam int TRAIN_W  = 192;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 64;

  localparam logic [1:0] REG_TRAIN_A = 2'd0;
  localparam logic [1:0] REG_TRAIN_B = 2'd1;
  localparam logic [1:0] REG_TRAIN_C = 2'd2;

  typedef struct packed {
    logic signed [15:0] sample_re;
    logic signed [15:0] sample_im;
    logic               window_end;
  } sample_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] peak_offset;
    logic [POWER_W-1:0]  peak_power;
    logic                no_peak;
  } result_t;

  typedef struct packed {
    logic load;
    logic rotate;
    logic clear;
  } corr_ctrl_t;

  typedef struct packed {
    logic sq_re;
    logic sq_im;
    logic cmp;
    logic clear;
  } peak_ctrl_t;

endpackage

// ----- rtl/tcps_corr.sv -----
// ----------------------------------------------------------------------------
// tcps_corr
// Delay line that rotates one tap per cycle past a single complex MAC.
// ----------------------------------------------------------------------------
module tcps_corr #(
  parameter int TRAIN_SYMBOLS = tcps_pkg::TRAIN_SYMBOLS_DEF,
  parameter int HOLD_FACTOR   = tcps_pkg::HOLD_FACTOR_DEF,
  parameter int TAPS          = TRAIN_SYMBOLS * HOLD_FACTOR,
  parameter int ACC_W         = 25 + $clog2(TAPS),
  parameter int TAP_W         = $clog2(TAPS + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  tcps_pkg::corr_ctrl_t            ctrl,
  input  logic [31:0]                     word_in,
  input  logic [tcps_pkg::TRAIN_W-1:0]    train,
  output logic signed [ACC_W-1:0]         acc_re,
  output logic signed [ACC_W-1:0]         acc_im,
  output logic                            mac_last
);

  logic [31:0]                     line [TAPS];
  logic [TAP_W-1:0]                tap;
  logic [tcps_pkg::SYM_W-1:0]      sym;
  logic [tcps_pkg::HOLD_W-1:0]     hold;
  logic [15:0]                     tb;
  logic signed [15:0]              sr, si;
  logic signed [7:0]               tr, ti;
  logic signed [23:0]              p_rr, p_ii, p_ir, p_ri;

  assign tb = train[int'(sym) * 16 +: 16];
  assign tr = $signed(tb[7:0]);
  assign ti = $signed(tb[15:8]);
  assign sr = $signed(line[TAPS-1][15:0]);
  assign si = $signed(line[TAPS-1][31:16]);
  assign p_rr = sr * tr;
  assign p_ii = si * ti;
  assign p_ir = si * tr;
  assign p_ri = sr * ti;
  assign mac_last = (tap == TAP_W'(TAPS - 1));

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      for (int i = 0; i < TAPS; i++) line[i] <= '0;
      acc_re <= '0;
      acc_im <= '0;
      tap    <= '0;
      sym    <= '0;
      hold   <= '0;
    end else if (ctrl.load) begin
      line[0] <= word_in;
      for (int i = 1; i < TAPS; i++) line[i] <= line[i-1];
      acc_re <= '0;
      acc_im <= '0;
      tap    <= '0;
      sym    <= '0;
      hold   <= '0;
    end else if (ctrl.rotate) begin
      // oldest slot feeds the MAC and wraps to the front
      line[0] <= line[TAPS-1];
      for (int i = 1; i < TAPS; i++) line[i] <= line[i-1];
      acc_re <= acc_re + ACC_W'(p_rr) + ACC_W'(p_ii);
      acc_im <= acc_im + ACC_W'(p_ir) - ACC_W'(p_ri);
      tap    <= tap + TAP_W'(1);
      if (hold == tcps_pkg::HOLD_W'(HOLD_FACTOR - 1)) begin
        hold <= '0;
        sym  <= sym + tcps_pkg::SYM_W'(1);
      end else begin
        hold <= hold + tcps_pkg::HOLD_W'(1);
      end
    end
  end

endmodule

// ----- rtl/tcps_peak.sv -----
// ----------------------------------------------------------------------------
// tcps_peak
// Squared magnitude over one shared multiplier, saturation and best tracking.
// ----------------------------------------------------------------------------
module tcps_peak #(
  parameter int ACC_W = 30,
  parameter int PW_W  = (2 * ACC_W + 1 > tcps_pkg::POWER_W + 1) ?
                        2 * ACC_W + 1 : tcps_pkg::POWER_W + 1
) (
  input  logic                             clk,
  input  logic                             rst,
  input  tcps_pkg::peak_ctrl_t             ctrl,
  input  logic signed [ACC_W-1:0]          acc_re,
  input  logic signed [ACC_W-1:0]          acc_im,
  input  logic [tcps_pkg::OFFSET_W-1:0]    offset,
  output logic [tcps_pkg::POWER_W-1:0]     best_power,
  output logic [tcps_pkg::OFFSET_W-1:0]    best_offset
);

  localparam logic [tcps_pkg::POWER_W-1:0] POWER_MAX = '1;

  logic signed [ACC_W-1:0]       op_s;
  logic [ACC_W-1:0]              op_abs;
  logic [2*ACC_W-1:0]            sq;
  logic [PW_W-1:0]               pw;
  logic [tcps_pkg::POWER_W-1:0]  pw_sat;

  assign op_s   = ctrl.sq_re ? acc_re : acc_im;
  assign op_abs = op_s[ACC_W-1] ? ACC_W'(-op_s) : ACC_W'(op_s);
  assign sq     = op_abs * op_abs;
  assign pw_sat = (pw > PW_W'(POWER_MAX)) ? POWER_MAX : pw[tcps_pkg::POWER_W-1:0];

  always_ff @(posedge clk) begin
    if (ctrl.sq_re) pw <= PW_W'(sq);
    else if (ctrl.sq_im) pw <= pw + PW_W'(sq);
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      best_power  <= '0;
      best_offset <= '0;
    end else if (ctrl.cmp && (pw_sat > best_power)) begin
      best_power  <= pw_sat;
      best_offset <= offset;
    end
  end

endmodule

// ----- rtl/training_correlator_peak_search_unit.sv -----
// ----------------------------------------------------------------------------
// training_correlator_peak_search_unit
// Cross-correlation timing search against a held training sequence.
// ----------------------------------------------------------------------------
// Each accepted sample item, up to MAX_WINDOW per window, enters a TAPS-deep
// delay line (TAPS = TRAIN_SYMBOLS * HOLD_FACTOR). Once enough samples are
// in, the line rotates past a single complex multiply-accumulate, one tap
// per cycle, then one shared squarer forms re^2 and im^2 and the result is
// compared against the best so far. in_ready is low from acceptance until
// the block is idle again, so no new sample item is taken while the last
// one is still in process. The item carrying window_end also runs TAPS-1
// zero-flush steps before the result item is offered.
// The result sits in an output register; if it has not been taken when the
// next window ends, the block waits. Training words are 64-bit APB
// registers at byte offsets 0, 8 and 16; write them only while idle.
`include "training_correlator_peak_search_unit_macros.svh"

module training_correlator_peak_search_unit #(
  parameter int TRAIN_SYMBOLS = tcps_pkg::TRAIN_SYMBOLS_DEF,
  parameter int HOLD_FACTOR   = tcps_pkg::HOLD_FACTOR_DEF,
  parameter int MAX_WINDOW    = tcps_pkg::MAX_WINDOW_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tcps_pkg::sample_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tcps_pkg::result_t             out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tcps_pkg::ADDR_W-1:0]   paddr,
  input  logic [tcps_pkg::DATA_W-1:0]   pwdata,
  output logic [tcps_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int TAPS  = TRAIN_SYMBOLS * HOLD_FACTOR;
  localparam int ACC_W = 25 + $clog2(TAPS);
  localparam int TAP_W = $clog2(TAPS + 1);
  localparam int POS_W = tcps_pkg::OFFSET_W;
  localparam int P_W   = POS_W + 1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MAC  = 7'b0000010,
    S_SQR  = 7'b0000100,
    S_SQI  = 7'b0001000,
    S_CMP  = 7'b0010000,
    S_NEXT = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  state_t state, state_next;

  // training registers
  logic [63:0] train_a, train_b, train_c;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      train_a <= '0;
      train_b <= '0;
      train_c <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[4:3])
        tcps_pkg::REG_TRAIN_A: train_a <= pwdata;
        tcps_pkg::REG_TRAIN_B: train_b <= pwdata;
        tcps_pkg::REG_TRAIN_C: train_c <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      tcps_pkg::REG_TRAIN_A: prdata = train_a;
      tcps_pkg::REG_TRAIN_B: prdata = train_b;
      tcps_pkg::REG_TRAIN_C: prdata = train_c;
      default:               prdata = '0;
    endcase
  end

  // window control
  logic [POS_W-1:0]  pos;
  logic [TAP_W-1:0]  fcnt;
  logic [P_W-1:0]    cur_p;
  logic              end_r;
  logic              accept;
  logic              take;
  logic [P_W-1:0]    flush_p;

  tcps_pkg::corr_ctrl_t cctrl;
  tcps_pkg::peak_ctrl_t pctrl;
  logic [31:0]          word_in;
  logic signed [ACC_W-1:0] acc_re, acc_im;
  logic                 mac_last;
  logic [tcps_pkg::POWER_W-1:0]  best_power;
  logic [tcps_pkg::OFFSET_W-1:0] best_offset;
  logic [tcps_pkg::OFFSET_W-1:0] cur_offset;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign take     = (pos < POS_W'(MAX_WINDOW));
  assign flush_p  = P_W'(pos) + P_W'(fcnt);
  assign cur_offset = tcps_pkg::OFFSET_W'(cur_p + P_W'(2) - P_W'(TAPS));
  assign word_in  = (state == S_IDLE) ? {in_data.sample_im, in_data.sample_re} : 32'd0;

  always_comb begin
    state_next   = state;
    cctrl        = '0;
    pctrl        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cctrl.load = take;
          if (take && (P_W'(pos) + P_W'(2) >= P_W'(TAPS))) state_next = S_MAC;
          else state_next = S_NEXT;
        end
      end
      S_MAC: begin
        cctrl.rotate = 1'b1;
        if (mac_last) state_next = S_SQR;
      end
      S_SQR: begin
        pctrl.sq_re = 1'b1;
        state_next  = S_SQI;
      end
      S_SQI: begin
        pctrl.sq_im = 1'b1;
        state_next  = S_CMP;
      end
      S_CMP: begin
        pctrl.cmp  = 1'b1;
        state_next = S_NEXT;
      end
      S_NEXT: begin
        priority if (!end_r) begin
          state_next = S_IDLE;
        end else if (P_W'(fcnt) + P_W'(1) < P_W'(TAPS)) begin
          cctrl.load = 1'b1;
          if (flush_p + P_W'(2) >= P_W'(TAPS)) state_next = S_MAC;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid) begin
          cctrl.clear = 1'b1;
          pctrl.clear = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pos   <= '0;
      fcnt  <= '0;
      cur_p <= '0;
      end_r <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        end_r <= in_data.window_end;
        cur_p <= P_W'(pos);
        if (take) pos <= pos + POS_W'(1);
      end
      if ((state == S_NEXT) && end_r && (P_W'(fcnt) + P_W'(1) < P_W'(TAPS))) begin
        cur_p <= flush_p;
        fcnt  <= fcnt + TAP_W'(1);
      end
      if (cctrl.clear) begin
        pos   <= '0;
        fcnt  <= '0;
        end_r <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_FIN) && !out_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_FIN) && !out_valid) begin
      out_data.no_peak     <= (best_power == '0);
      out_data.peak_power  <= best_power;
      out_data.peak_offset <= (best_power == '0) ? '0 : best_offset;
    end
  end

  tcps_corr #(
    .TRAIN_SYMBOLS (TRAIN_SYMBOLS),
    .HOLD_FACTOR   (HOLD_FACTOR),
    .TAPS          (TAPS),
    .ACC_W         (ACC_W),
    .TAP_W         (TAP_W)
  ) u_corr (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (cctrl),
    .word_in  (word_in),
    .train    ({train_c, train_b, train_a}),
    .acc_re   (acc_re),
    .acc_im   (acc_im),
    .mac_last (mac_last)
  );

  tcps_peak #(
    .ACC_W (ACC_W)
  ) u_peak (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (pctrl),
    .acc_re      (acc_re),
    .acc_im      (acc_im),
    .offset      (cur_offset),
    .best_power  (best_power),
    .best_offset (best_offset)
  );

  `TCPS_ASSERT(a_no_peak_zero, (out_valid && out_data.no_peak) |-> ((out_data.peak_power == '0) && (out_data.peak_offset == '0)), "no_peak result carries nonzero fields")
  `TCPS_ASSERT(a_best_grows, (!$past(pctrl.clear)) |-> (best_power >= $past(best_power)), "best power dropped inside a window")
  `TCPS_ASSERT_NEXT(a_mac_to_sq, (state == S_MAC) && mac_last, state == S_SQR, "MAC loop did not hand over to squaring")
  `TCPS_ASSERT(a_pos_bound, (pos <= POS_W'(MAX_WINDOW)), "sample count beyond window limit")

endmodule
